// ----- src/ivpr_pkg.sv -----
// Shared types and constants for the interlaced video packet reassembler.
package ivpr_pkg;

  // Field widths.
  localparam int DATA_W  = 8;
  localparam int LEN_W   = 12;
  localparam int LB_W    = 12;
  localparam int FL_W    = 10;
  localparam int ADDR_W  = 22;
  localparam int HDR_W   = 3;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 12;

  // Packet framing constants.
  localparam int HEADER_BYTES = 4;
  localparam logic [HDR_W-1:0] HEADER_LEFT_INIT = HDR_W'(HEADER_BYTES - 1);
  localparam logic [LEN_W-1:0] SHORT_LEN  = LEN_W'(4);
  localparam logic [DATA_W-1:0] MARK_END   = 8'hc0;
  localparam logic [DATA_W-1:0] MARK_FIELD = 8'h80;
  localparam int PARITY_BIT = 6;
  localparam logic [ADDR_W-1:0] COUNT_MAX = {ADDR_W{1'b1}};

  // Register reset values.
  localparam logic [LB_W-1:0] LINE_BYTES_RST  = LB_W'(1440);
  localparam logic [FL_W-1:0] FRAME_LINES_RST = FL_W'(480);

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_LINE_BYTES  = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_FRAME_LINES = CIDX_W'(1);

  // Result event codes.
  localparam logic EV_WRITE    = 1'b0;
  localparam logic EV_COMPLETE = 1'b1;

  typedef enum logic [1:0] {
    MODE_DISCARD = 2'd0,
    MODE_HEADER  = 2'd1,
    MODE_DATA    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first_of_packet;
    logic [LEN_W-1:0]  packet_length;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              event_res;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic [ADDR_W-1:0] frame_byte_count;
  } result_t;

  typedef struct packed {
    logic [LB_W-1:0] line_bytes;
    logic [FL_W-1:0] frame_lines;
  } cfg_t;

endpackage

// ----- src/interlaced_video_packet_reassembler_top.sv -----
// Top level of the interlaced video packet reassembler.
//
// Input channel: one packet byte per transfer (data_byte, first_of_packet,
// packet_length), taken at an edge with in_valid high and in_stall low.
// Output channel: frame byte writes and frame complete events, one per
// transfer, taken at an edge with out_valid high and out_stall low.
// Configuration: cfg_index selects line_bytes (0) or frame_lines (1);
// cfg_ready is always high, so each cfg_valid cycle is a write.
// A byte enters the input register, is parsed while it is held there, and
// its result, if any, is registered in the output register when the byte
// moves on. Throughput is one byte per cycle while no stalled result holds
// the flow, set by the single parse stage whose state feeds back on itself.
// While the output register holds an untaken result and out_stall is high,
// a byte that makes no result still passes; a byte that makes one waits,
// and in_stall rises. Reset clears both registers, sets line_bytes to 1440
// and frame_lines to 480, and leaves the parser discarding until the
// next packet start.
module interlaced_video_packet_reassembler_top
  import ivpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  data_byte,
  input  logic               first_of_packet,
  input  logic [LEN_W-1:0]   packet_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               event_res,
  output logic [ADDR_W-1:0]  write_address,
  output logic [DATA_W-1:0]  write_data,
  output logic [ADDR_W-1:0]  frame_byte_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t res;
  logic    advance;
  logic    in_take;

  ivpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ivpr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .commit (advance),
    .cfg    (cfg),
    .res    (res)
  );

  // The held byte moves on unless its result would land on a stalled one.
  assign advance  = item_valid && (!res.valid || !out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.data_byte       <= data_byte;
      item.first_of_packet <= first_of_packet;
      item.packet_length   <= packet_length;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      event_res        <= res.event_res;
      write_address    <= res.write_address;
      write_data       <= res.write_data;
      frame_byte_count <= res.frame_byte_count;
    end
  end

  // A parsed result always shows up in the output register.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    advance && res.valid |=> out_valid)
    else $error("parsed result not presented");

  // The input side only stalls while a byte is held.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && res.valid && out_valid && out_stall)
    else $error("input stalled without cause");

  // A stalled result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(advance && res.valid))
    else $error("stalled result overwritten");

endmodule

// ----- src/ivpr_cfg.sv -----
// Configuration register file: line length and frame height.
module ivpr_cfg
  import ivpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output cfg_t               cfg
);

  logic [LB_W-1:0] line_bytes;
  logic [FL_W-1:0] frame_lines;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Decode the register index on each write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes  <= LINE_BYTES_RST;
      frame_lines <= FRAME_LINES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_BYTES:  line_bytes  <= cfg_data[LB_W-1:0];
        REG_FRAME_LINES: frame_lines <= cfg_data[FL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.line_bytes  = line_bytes;
  assign cfg.frame_lines = frame_lines;

endmodule

// ----- src/ivpr_core.sv -----
// Packet parser and frame position state; computes at most one result per byte.
module ivpr_core
  import ivpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    commit,
  input  cfg_t    cfg,
  output result_t res
);

  mode_t             mode, mode_next;
  logic              field_odd, field_odd_next;
  logic [FL_W-1:0]   field_line, field_line_next;
  logic [LB_W-1:0]   line_offset, line_offset_next;
  logic [ADDR_W-1:0] bytes_used, bytes_used_next;
  logic [HDR_W-1:0]  header_left, header_left_next;

  logic [FL_W:0]     dst_line;
  logic [ADDR_W:0]   line_base;
  logic [ADDR_W:0]   addr_sum;
  logic [LB_W:0]     offset_inc;
  logic [HDR_W-1:0]  header_dec;
  logic              is_marker;

  // Destination line and store address of a picture byte.
  assign dst_line   = {field_line, ~field_odd};
  assign line_base  = (ADDR_W + 1)'(dst_line) * (ADDR_W + 1)'(cfg.line_bytes);
  assign addr_sum   = line_base + (ADDR_W + 1)'(line_offset);
  assign offset_inc = {1'b0, line_offset} + (LB_W + 1)'(1);
  assign header_dec = header_left - HDR_W'(1);
  assign is_marker  = (item.data_byte == MARK_END) || (item.data_byte == MARK_FIELD);

  // Next state and result for the byte in the input register.
  always_comb begin
    mode_next        = mode;
    field_odd_next   = field_odd;
    field_line_next  = field_line;
    line_offset_next = line_offset;
    bytes_used_next  = bytes_used;
    header_left_next = header_left;
    res              = '0;
    if (item.first_of_packet) begin
      if (item.packet_length <= SHORT_LEN) begin
        mode_next = MODE_DISCARD;
      end else if (is_marker) begin
        if (item.data_byte == MARK_END) begin
          res.valid            = 1'b1;
          res.event_res        = EV_COMPLETE;
          res.frame_byte_count = bytes_used;
          bytes_used_next      = '0;
        end
        field_odd_next   = item.data_byte[PARITY_BIT];
        field_line_next  = '0;
        line_offset_next = '0;
        mode_next        = MODE_DISCARD;
      end else begin
        header_left_next = HEADER_LEFT_INIT;
        mode_next        = (HEADER_LEFT_INIT == '0) ? MODE_DATA : MODE_HEADER;
      end
    end else begin
      unique case (mode)
        MODE_HEADER: begin
          header_left_next = header_dec;
          if (header_dec == '0) begin
            mode_next = MODE_DATA;
          end
        end
        MODE_DATA: begin
          if (dst_line >= {1'b0, cfg.frame_lines}) begin
            mode_next = MODE_DISCARD;
          end else begin
            res.valid         = 1'b1;
            res.event_res     = EV_WRITE;
            res.write_address = addr_sum[ADDR_W-1:0];
            res.write_data    = item.data_byte;
            if (bytes_used != COUNT_MAX) begin
              bytes_used_next = bytes_used + ADDR_W'(1);
            end
            if (offset_inc >= {1'b0, cfg.line_bytes}) begin
              line_offset_next = '0;
              field_line_next  = field_line + FL_W'(1);
            end else begin
              line_offset_next = offset_inc[LB_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State update when the byte moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_DISCARD;
      field_odd   <= 1'b0;
      field_line  <= '0;
      line_offset <= '0;
      bytes_used  <= '0;
      header_left <= '0;
    end else if (commit) begin
      mode        <= mode_next;
      field_odd   <= field_odd_next;
      field_line  <= field_line_next;
      line_offset <= line_offset_next;
      bytes_used  <= bytes_used_next;
      header_left <= header_left_next;
    end
  end

  // A frame complete result clears the byte count.
  a_complete_clears: assert property (@(posedge clk) disable iff (rst)
    commit && res.valid && (res.event_res == EV_COMPLETE) |=> bytes_used == '0)
    else $error("byte count not cleared after frame complete");

  // Header countdown stays within the header length.
  a_header_range: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HEADER) |-> (header_left != '0) && (header_left <= HEADER_LEFT_INIT))
    else $error("header countdown out of range");

  // Writes only come from data mode and never from a first byte.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.event_res == EV_WRITE) |-> (mode == MODE_DATA) && !item.first_of_packet)
    else $error("write result outside data mode");

endmodule
